>>> rtl/core/upe_pkg.sv
package upe_pkg;

  localparam logic [7:0] PctChar = 8'h25;

  localparam int QueueDepth = 4;
  localparam int QPtrW      = $clog2(QueueDepth);
  localparam int QCntW      = $clog2(QueueDepth + 1);

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       string_last;
  } out_item_t;

  // one token expands to one byte, or to three when esc is set
  typedef struct packed {
    logic [7:0] value;
    logic       esc;
    logic       run_last;
    logic       string_last;
  } token_t;

  typedef enum logic [1:0] {
    HeldNone     = 2'd0,
    HeldPct      = 2'd1,
    HeldPctDigit = 2'd2
  } held_e;

  function automatic logic is_hex(input logic [7:0] c);
    return c inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]};
  endfunction

  // letters, digits and the punctuation that passes unchanged
  function automatic logic is_plain(input logic [7:0] c);
    return c inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A],
                     8'h2D, 8'h2E, 8'h5F, 8'h7E, 8'h21, 8'h24, 8'h26,
                     8'h27, 8'h28, 8'h29, 8'h2A, 8'h2B, 8'h2C, 8'h3B,
                     8'h3D, 8'h3A, 8'h40, 8'h2F, 8'h3F, 8'h5B, 8'h5D};
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] base;
    base = (nib < 4'd10) ? 8'h30 : 8'h37;
    return base + {4'd0, nib};
  endfunction

  function automatic token_t mk_token(input logic [7:0] value, input logic esc);
    token_t t;
    t.value       = value;
    t.esc         = esc;
    t.run_last    = 1'b0;
    t.string_last = 1'b0;
    return t;
  endfunction

endpackage

>>> rtl/core/url_percent_encoder_unit.sv
// url percent encoder: raw url bytes in, percent-encoded bytes out
// input channel: in_valid_i / in_stall_o, one byte and its end-of-string flag per transfer
// output channel: out_valid_o / out_stall_i, one encoded byte per transfer, with run_last
//   on the final byte caused by an input and string_last on the final byte of the string
// an input gives 0 to 7 output bytes; a '%' and one hex digit after it are held until
//   the next byte decides whether they form an existing escape
// the front turns each input into up to three tokens (a literal byte or a %XX escape each),
//   one token a cycle unless the queue is full, taking a new byte as its last token leaves
// a four-entry token queue sits between front and back
// the back emits one byte a cycle unless stalled: 1 byte per literal token, 3 per escape
// the byte-wide output limits how fast inputs are taken
// on an empty pipe a byte passes the front buffer, queue, token register and output register
// reset clears the held bytes, the queue and all valid flags
// a stall on the output holds the registered byte; the queue and front fill up, then
//   in_stall_o rises
module url_percent_encoder_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  upe_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output upe_pkg::out_item_t out_data_o
);
  import upe_pkg::*;

  logic   f_valid;
  token_t f_data;
  logic   q_full;
  logic   q_valid;
  token_t q_data;
  logic   q_pop;

  upe_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .tok_valid_o (f_valid),
    .tok_data_o  (f_data),
    .tok_full_i  (q_full)
  );

  upe_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (f_valid),
    .push_data_i (f_data),
    .full_o      (q_full),
    .pop_valid_o (q_valid),
    .pop_data_o  (q_data),
    .pop_i       (q_pop)
  );

  upe_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tok_valid_i (q_valid),
    .tok_data_i  (q_data),
    .tok_pop_o   (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

>>> rtl/core/upe_front.sv
module upe_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  upe_pkg::in_item_t in_data_i,
  output logic              tok_valid_o,
  output upe_pkg::token_t   tok_data_o,
  input  logic              tok_full_i
);
  import upe_pkg::*;

  held_e      held_q, held_d;
  logic [7:0] digit_q, digit_d;
  token_t     buf_q [3];
  token_t     buf_d [3];
  logic [1:0] cnt_q, cnt_d;

  token_t     lst [3];
  logic [1:0] n;
  held_e      hold;
  logic [7:0] dig;
  logic       do_fresh;
  logic [7:0] c;
  logic       acc;
  logic       push;

  assign c = in_data_i.in_byte;

  // split the byte and the held bytes into tokens, at most three
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      lst[i] = '0;
    end
    n        = 2'd0;
    hold     = HeldNone;
    dig      = digit_q;
    do_fresh = 1'b0;

    case (held_q)
      HeldPct: begin
        if (is_hex(c)) begin
          hold = HeldPctDigit;
          dig  = c;
        end else begin
          lst[n]   = mk_token(PctChar, 1'b1);
          n        = n + 2'd1;
          do_fresh = 1'b1;
        end
      end
      HeldPctDigit: begin
        if (is_hex(c)) begin
          lst[0] = mk_token(PctChar, 1'b0);
          lst[1] = mk_token(digit_q, 1'b0);
          lst[2] = mk_token(c, 1'b0);
          n      = 2'd3;
        end else begin
          lst[0]   = mk_token(PctChar, 1'b1);
          lst[1]   = mk_token(digit_q, !is_plain(digit_q));
          n        = 2'd2;
          do_fresh = 1'b1;
        end
      end
      default: begin
        do_fresh = 1'b1;
      end
    endcase

    if (do_fresh) begin
      if (c == PctChar) begin
        hold = HeldPct;
      end else begin
        lst[n] = mk_token(c, !is_plain(c));
        n      = n + 2'd1;
      end
    end

    // end of string flushes whatever is still held
    if (in_data_i.in_last) begin
      if (hold == HeldPct) begin
        lst[n] = mk_token(PctChar, 1'b1);
        n      = n + 2'd1;
      end else if (hold == HeldPctDigit) begin
        lst[n] = mk_token(PctChar, 1'b1);
        n      = n + 2'd1;
        lst[n] = mk_token(dig, !is_plain(dig));
        n      = n + 2'd1;
      end
      hold = HeldNone;
      dig  = 8'd0;
    end

    for (int i = 0; i < 3; i++) begin
      if (n != 2'd0 && (2'(i) + 2'd1) == n) begin
        lst[i].run_last    = 1'b1;
        lst[i].string_last = in_data_i.in_last;
      end
    end
  end

  assign push        = (cnt_q != 2'd0) && !tok_full_i;
  assign in_stall_o  = !((cnt_q == 2'd0) || (cnt_q == 2'd1 && push));
  assign acc         = in_valid_i && !in_stall_o;
  assign tok_valid_o = cnt_q != 2'd0;
  assign tok_data_o  = buf_q[0];

  always_comb begin
    held_d  = held_q;
    digit_d = digit_q;
    cnt_d   = cnt_q;
    buf_d   = buf_q;
    if (acc) begin
      held_d  = hold;
      digit_d = dig;
      cnt_d   = n;
      buf_d   = lst;
    end else if (push) begin
      buf_d[0] = buf_q[1];
      buf_d[1] = buf_q[2];
      cnt_d    = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q  <= HeldNone;
      digit_q <= 8'd0;
      cnt_q   <= 2'd0;
    end else begin
      held_q  <= held_d;
      digit_q <= digit_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    buf_q <= buf_d;
  end

endmodule

>>> rtl/core/upe_queue.sv
module upe_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  upe_pkg::token_t push_data_i,
  output logic            full_o,
  output logic            pop_valid_o,
  output upe_pkg::token_t pop_data_o,
  input  logic            pop_i
);
  import upe_pkg::*;

  token_t           mem_q [QueueDepth];
  logic [QPtrW-1:0] wr_q, wr_d;
  logic [QPtrW-1:0] rd_q, rd_d;
  logic [QCntW-1:0] cnt_q, cnt_d;
  logic             do_push;
  logic             do_pop;

  assign full_o      = cnt_q == QCntW'(QueueDepth);
  assign pop_valid_o = cnt_q != '0;
  assign pop_data_o  = mem_q[rd_q];
  assign do_push     = push_i && !full_o;
  assign do_pop      = pop_i && pop_valid_o;

  always_comb begin
    wr_d  = do_push ? wr_q + QPtrW'(1) : wr_q;
    rd_d  = do_pop ? rd_q + QPtrW'(1) : rd_q;
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + QCntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - QCntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

endmodule

>>> rtl/core/upe_back.sv
module upe_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               tok_valid_i,
  input  upe_pkg::token_t    tok_data_i,
  output logic               tok_pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output upe_pkg::out_item_t out_data_o
);
  import upe_pkg::*;

  token_t     cur_q, cur_d;
  logic       cur_valid_q, cur_valid_d;
  logic [1:0] phase_q, phase_d;
  logic       out_valid_q, out_valid_d;
  out_item_t  out_q, out_d;

  logic       load_out;
  logic       tok_end;
  logic       fin;
  logic [7:0] cur_byte;

  assign load_out  = !out_valid_q || !out_stall_i;
  assign tok_end   = cur_q.esc ? (phase_q == 2'd2) : 1'b1;
  assign fin       = cur_valid_q && load_out && tok_end;
  assign tok_pop_o = tok_valid_i && (!cur_valid_q || fin);

  always_comb begin
    cur_byte = cur_q.value;
    if (cur_q.esc) begin
      case (phase_q)
        2'd1:    cur_byte = hex_char(cur_q.value[7:4]);
        2'd2:    cur_byte = hex_char(cur_q.value[3:0]);
        default: cur_byte = PctChar;
      endcase
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (load_out) begin
      out_valid_d       = cur_valid_q;
      out_d.out_byte    = cur_byte;
      out_d.run_last    = tok_end && cur_q.run_last;
      out_d.string_last = tok_end && cur_q.string_last;
    end
  end

  always_comb begin
    cur_d       = cur_q;
    cur_valid_d = cur_valid_q;
    phase_d     = phase_q;
    if (tok_pop_o) begin
      cur_d       = tok_data_i;
      cur_valid_d = 1'b1;
      phase_d     = 2'd0;
    end else if (fin) begin
      cur_valid_d = 1'b0;
    end else if (cur_valid_q && load_out) begin
      phase_d = phase_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      phase_q     <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      cur_valid_q <= cur_valid_d;
      phase_q     <= phase_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

>>> verif/url_percent_encoder_unit_test.sv
module url_percent_encoder_unit_test;
  import upe_pkg::*;

  localparam int CycleLimit   = 200000;
  localparam int DirectedLen  = 25;
  localparam int RandomItems  = 225;
  localparam int QuietTail    = 40;
  localparam int DrainCycles  = 20;

  class pct_encode_board;
    held_e      held_q;
    logic [7:0] digit_q;
    logic [7:0] run_q[$];
    out_item_t  encoded_q[$];
    string      digits = "0123456789ABCDEF";
    int         n_inputs;
    int         n_checked;
    int         n_errors;

    function new();
      held_q  = HeldNone;
      digit_q = '0;
    endfunction

    function bit hex_digit(logic [7:0] c);
      return (c >= "0" && c <= "9") || (c >= "A" && c <= "F") || (c >= "a" && c <= "f");
    endfunction

    function bit passes(logic [7:0] c);
      if ((c >= "0" && c <= "9") || (c >= "A" && c <= "Z") || (c >= "a" && c <= "z"))
        return 1'b1;
      case (c)
        "-", ".", "_", "~", "!", "$", "&", "'", "(", ")", "*", "+", ",", ";",
        "=", ":", "@", "/", "?", "[", "]": return 1'b1;
        default: return 1'b0;
      endcase
    endfunction

    function void put_escaped(logic [7:0] c);
      run_q.push_back(PctChar);
      run_q.push_back(digits[c[7:4]]);
      run_q.push_back(digits[c[3:0]]);
    endfunction

    function void put_plain(logic [7:0] c);
      if (passes(c)) run_q.push_back(c);
      else put_escaped(c);
    endfunction

    function void take_fresh(logic [7:0] c);
      if (c == PctChar) held_q = HeldPct;
      else put_plain(c);
    endfunction

    function void note_input(in_item_t item);
      logic [7:0] c;
      out_item_t  e;
      c = item.in_byte;
      run_q.delete();
      n_inputs++;
      case (held_q)
        HeldPct: begin
          if (hex_digit(c)) begin
            held_q  = HeldPctDigit;
            digit_q = c;
          end else begin
            held_q = HeldNone;
            put_escaped(PctChar);
            take_fresh(c);
          end
        end
        HeldPctDigit: begin
          held_q = HeldNone;
          if (hex_digit(c)) begin
            // an existing escape passes through as it is
            run_q.push_back(PctChar);
            run_q.push_back(digit_q);
            run_q.push_back(c);
          end else begin
            put_escaped(PctChar);
            put_plain(digit_q);
            take_fresh(c);
          end
        end
        default: begin
          held_q = HeldNone;
          take_fresh(c);
        end
      endcase
      if (item.in_last) begin
        // flush whatever is still held at end of string
        if (held_q == HeldPct) begin
          put_escaped(PctChar);
        end else if (held_q == HeldPctDigit) begin
          put_escaped(PctChar);
          put_plain(digit_q);
        end
        held_q  = HeldNone;
        digit_q = '0;
      end
      foreach (run_q[k]) begin
        e.out_byte    = run_q[k];
        e.run_last    = (k == run_q.size() - 1);
        e.string_last = (k == run_q.size() - 1) && item.in_last;
        encoded_q.push_back(e);
      end
    endfunction

    function void check_output(out_item_t got);
      out_item_t want;
      if (encoded_q.size() == 0) begin
        $error("out_byte expected none got %h", got.out_byte);
        n_errors++;
        return;
      end
      want = encoded_q.pop_front();
      n_checked++;
      if (got.out_byte !== want.out_byte) begin
        $error("out_byte expected %h got %h", want.out_byte, got.out_byte);
        n_errors++;
      end
      if (got.run_last !== want.run_last) begin
        $error("run_last expected %b got %b", want.run_last, got.run_last);
        n_errors++;
      end
      if (got.string_last !== want.string_last) begin
        $error("string_last expected %b got %b", want.string_last, got.string_last);
        n_errors++;
      end
    endfunction

    function int pending();
      return encoded_q.size();
    endfunction
  endclass

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_stall_o;
  in_item_t  in_data_i   = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_item_t out_data_o;

  pct_encode_board board = new();

  logic [7:0] raw_q[$];
  int    items_sent;
  int    strings_sent;
  int    cycle_cnt;
  int    gap_pct;
  bit    idle_on = 1'b1;
  bit    long_hold_done;
  string alnum_chars = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789";
  string punct_chars = "-._~!$&'()*+,;=:@/?[]";
  string hex_chars   = "0123456789abcdefABCDEF";

  url_percent_encoder_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) board.note_input(in_data_i);
      if (out_valid_o && !out_stall_i) board.check_output(out_data_o);
    end
  end

  initial begin
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("timeout after %0d cycles, %0d bytes still expected", cycle_cnt, board.pending());
    $display("url_percent_encoder_unit_test: FAIL");
    $finish;
  end

  // output side: stall bursts, plus one long hold-off to back the block up
  initial begin
    int n;
    bit v;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (!long_hold_done && items_sent >= 60) begin
        long_hold_done = 1'b1;
        v = 1'b1;
        n = 120;
      end else if (idle_on && $urandom_range(0, 2) == 0) begin
        v = 1'b1;
        n = $urandom_range(1, 5);
      end else begin
        v = 1'b0;
        n = $urandom_range(1, 8);
      end
      out_stall_i <= v;
      repeat (n) @(posedge clk_i);
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    in_item_t item;
    if (idle_on && $urandom_range(0, 99) < gap_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    item.in_byte = b;
    item.in_last = last;
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    // transfer happens at the first edge with stall low
    do @(posedge clk_i); while (in_stall_o);
    items_sent++;
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) raw_q.push_back(s[i]);
  endtask

  task automatic send_raw(input bit ends);
    gap_pct = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(10, 40);
    foreach (raw_q[i]) send_byte(raw_q[i], ends && (i == raw_q.size() - 1));
    raw_q.delete();
    if (ends) strings_sent++;
  endtask

  // mostly well-formed text and escapes, with broken escapes and arbitrary bytes mixed in
  task automatic queue_random_string();
    int len;
    int kind;
    len = $urandom_range(1, 12);
    for (int i = 0; i < len; i++) begin
      kind = $urandom_range(0, 9);
      case (kind)
        0, 1, 2: raw_q.push_back(alnum_chars[$urandom_range(0, alnum_chars.len() - 1)]);
        3: raw_q.push_back(punct_chars[$urandom_range(0, punct_chars.len() - 1)]);
        4: begin
          raw_q.push_back(PctChar);
          raw_q.push_back(hex_chars[$urandom_range(0, hex_chars.len() - 1)]);
          raw_q.push_back(hex_chars[$urandom_range(0, hex_chars.len() - 1)]);
        end
        5: begin
          raw_q.push_back(PctChar);
          raw_q.push_back(hex_chars[$urandom_range(0, hex_chars.len() - 1)]);
        end
        6: raw_q.push_back(PctChar);
        default: raw_q.push_back(8'($urandom_range(0, 255)));
      endcase
    end
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: plain, punctuation, escaped bytes, held '%' cases and flushes
    add_text("a9~");
    raw_q.push_back(8'h00);
    raw_q.push_back(8'hFF);
    add_text(" %41%g%Bz");
    send_raw(1'b0);
    add_text("%%");
    send_raw(1'b1);
    add_text("%a ");
    send_raw(1'b1);
    add_text("%c%");
    send_raw(1'b1);
    add_text("%");
    send_raw(1'b1);
    add_text("%f");
    send_raw(1'b1);

    while (items_sent < DirectedLen + RandomItems) begin
      if (items_sent > DirectedLen + RandomItems - QuietTail) idle_on = 1'b0;
      queue_random_string();
      send_raw($urandom_range(0, 7) != 0);
    end
    add_text("z");
    send_raw(1'b1);
    in_valid_i <= 1'b0;

    while (board.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("covered %0d input bytes in %0d terminated strings, %0d encoded bytes checked",
             board.n_inputs, strings_sent, board.n_checked);
    $display("including held-escape flushes, raw byte escapes and a long output hold-off");
    if (board.n_errors == 0) begin
      $display("url_percent_encoder_unit_test: PASS");
    end else begin
      $display("%0d mismatches", board.n_errors);
      $display("url_percent_encoder_unit_test: FAIL");
    end
    $finish;
  end

endmodule
